@@ hdl/scsc_pkg.sv @@
// Package for the segment slab clip core: types, op codes, sequencer states.
// No dependencies.
package scsc_pkg;
	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_CLIP = 2'd1,
		OP_INSIDE = 2'd2,
		OP_FACE = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DOT,
		ST_PLANE,
		ST_DIV,
		ST_NEXT,
		ST_LERP,
		ST_OUT
	} state_t;

	localparam int T_ONE = 65536;

	typedef struct packed {
		logic [1:0] op;
		logic [2:0] plane_index;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [31:0] plane_offset;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] end_z;
	} in_word_t;

	typedef struct packed {
		logic hit;
		logic [16:0] t_near;
		logic signed [31:0] hit_x;
		logic signed [31:0] hit_y;
		logic signed [31:0] hit_z;
		logic inside_res;
		logic negative_side;
	} out_word_t;
endpackage

@@ hdl/scsc_if.sv @@
// Valid/ready channel carrying one word of type word_t.
// No package dependencies; the word type is a parameter.
interface scsc_if #(parameter type word_t = logic) ();
	logic valid;
	logic ready;
	word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/scsc_mac.sv @@
// Shared multiply-accumulate unit: one 33x33 signed product per cycle, registered.
// No package dependencies.
module scsc_mac (
	input logic clk,
	input logic clr,
	input logic en,
	input logic signed [32:0] a,
	input logic signed [32:0] b,
	output logic signed [67:0] acc
);
	logic signed [65:0] prod_q;
	logic signed [67:0] acc_q;
	logic en_q, clr_q;
	always_ff @(posedge clk) begin
		prod_q <= a * b;
		en_q <= en;
		clr_q <= clr;
		if (clr_q)
			acc_q <= '0;
		else if (en_q)
			acc_q <= acc_q + 68'(prod_q);
	end
	assign acc = acc_q;
endmodule

@@ hdl/segment_convex_slab_clip_core.sv @@
// Segment clip against a convex body of PLANE_COUNT planes, one shared multiplier.
// Op 0 loads a plane and returns a result word. Op 2 tests each plane in turn.
// Op 3 compares the two face planes. Op 1 per plane: two dot products, a restoring
// divide and bookkeeping, cut short on an early t decision or a miss, then the
// entry point. One word in flight; a finished word waits in the
// output register. Reset clears the sequencer and output valid; planes undefined.
module segment_convex_slab_clip_core #(
	parameter int PLANE_COUNT = 5
) (
	input logic clk,
	input logic arst_n,
	scsc_if.sink in_ch,
	scsc_if.source out_ch
);
	import scsc_pkg::*;
	localparam int PW = $clog2(PLANE_COUNT);

	logic signed [15:0] nrm_q [PLANE_COUNT][3];
	logic signed [31:0] off_q [PLANE_COUNT];

	state_t state_q, state_d;
	in_word_t w_q;
	out_word_t res_q;
	out_word_t out_q;
	logic out_valid_q;
	logic out_load;
	logic [PW-1:0] pl_q;
	logic [2:0] step_q;
	logic [4:0] div_q;
	logic phase_q; // 0 start dot, 1 dir dot
	logic signed [67:0] dist_q, den_q, r_q;
	logic [16:0] q_q, tn_q, tf_q;
	logic inside_q, fail_q;
	logic [67:0] dneg_q;
	logic signed [31:0] hp_q [3];

	logic mac_clr, mac_en;
	logic signed [32:0] ma, mb;
	logic signed [67:0] acc;
	scsc_mac u_mac (.clk(clk), .clr(mac_clr), .en(mac_en), .a(ma), .b(mb), .acc(acc));

	function automatic logic signed [31:0] sel3(input in_word_t w, input logic e,
		input logic [1:0] k);
		logic signed [31:0] s, t;
		s = (k == 2'd0) ? w.start_x : (k == 2'd1) ? w.start_y : w.start_z;
		t = (k == 2'd0) ? w.end_x : (k == 2'd1) ? w.end_y : w.end_z;
		return e ? t : s;
	endfunction

	// operand selection for the shared multiplier
	logic signed [32:0] dir_k;
	always_comb begin
		dir_k = 33'(sel3(w_q, 1'b1, step_q[1:0])) - 33'(sel3(w_q, 1'b0, step_q[1:0]));
		ma = '0;
		mb = '0;
		mac_en = 1'b0;
		mac_clr = 1'b0;
		if (state_q == ST_DOT && step_q < 3'd3) begin
			ma = 33'(nrm_q[pl_q][step_q[1:0]]);
			mb = phase_q ? dir_k : 33'(sel3(w_q, 1'b0, step_q[1:0]));
			mac_en = 1'b1;
		end else if (state_q == ST_LERP && step_q < 3'd3) begin
			ma = dir_k;
			mb = 33'(tn_q);
			mac_en = 1'b1;
		end
		if (state_q == ST_IDLE || state_q == ST_NEXT || state_q == ST_PLANE ||
				state_q == ST_DIV)
			mac_clr = 1'b1;
		if (state_q == ST_LERP && step_q == 3'd5)
			mac_clr = 1'b1;
	end

	// divider operands: signs folded so the divisor is positive, and the shifted remainder
	logic signed [67:0] an, ad;
	always_comb begin
		an = den_q < 0 ? -dist_q : dist_q;
		ad = den_q < 0 ? -den_q : den_q;
	end
	logic signed [67:0] r2;
	assign r2 = r_q <<< 1;

	logic signed [67:0] dcur;
	assign dcur = acc - (68'(off_q[pl_q]) <<< 14); // n.s - offset

	// hand the finished word over once the output register is free
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_ch.valid && in_ch.ready) begin
				if (in_ch.data.op == OP_LOAD) state_d = ST_OUT;
				else state_d = ST_DOT;
			end
			ST_DOT: if (step_q == 3'd4) state_d = ST_PLANE;
			ST_PLANE: state_d = (phase_q || w_q.op != OP_CLIP) ? ST_DIV : ST_DOT;
			ST_DIV: if (div_q == 5'd17 || fail_q) state_d = ST_NEXT;
			ST_NEXT: if (fail_q) state_d = ST_OUT;
				else if (32'(pl_q) == PLANE_COUNT - 1) state_d = (w_q.op == OP_CLIP) ? ST_LERP : ST_OUT;
				else state_d = ST_DOT;
			ST_LERP: if (step_q == 3'd7) state_d = ST_OUT;
			ST_OUT: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	logic [67:0] absd;
	assign absd = dcur[67] ? 68'(-dcur) : 68'(dcur);
	logic signed [67:0] lp_q;
	logic signed [67:0] rnd;
	// round the newest product alone: accumulator minus the sum taken so far
	assign rnd = (acc - lp_q + 68'sd32768) >>> 16;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_ch.valid && in_ch.ready) begin
				w_q <= in_ch.data;
				res_q <= '0;
				pl_q <= (in_ch.data.op == OP_FACE) ? PW'(PLANE_COUNT - 2) : '0;
				step_q <= '0;
				phase_q <= 1'b0;
				tn_q <= '0;
				tf_q <= 17'(T_ONE);
				inside_q <= 1'b1;
				fail_q <= 1'b0;
				if (in_ch.data.op == OP_LOAD && 32'(in_ch.data.plane_index) < PLANE_COUNT) begin
					nrm_q[PW'(in_ch.data.plane_index)][0] <= in_ch.data.normal_x;
					nrm_q[PW'(in_ch.data.plane_index)][1] <= in_ch.data.normal_y;
					nrm_q[PW'(in_ch.data.plane_index)][2] <= in_ch.data.normal_z;
					off_q[PW'(in_ch.data.plane_index)] <= in_ch.data.plane_offset;
				end
			end
			ST_DOT: step_q <= step_q + 3'd1;
			ST_PLANE: begin
				step_q <= '0;
				if (!phase_q) begin
					dist_q <= -dcur;
					if (w_q.op == OP_INSIDE && !dcur[67]) inside_q <= 1'b0;
					if (w_q.op == OP_FACE) begin
						if (32'(pl_q) == PLANE_COUNT - 2) dneg_q <= absd;
						// compare at negative face: absd is dneg, dneg_q holds dpos
						else res_q.negative_side <= absd < dneg_q;
					end
					if (w_q.op == OP_CLIP) phase_q <= 1'b1;
					else begin
						div_q <= 5'd17;
					end
				end else begin
					den_q <= acc;
					phase_q <= 1'b0;
					div_q <= '0;
					r_q <= '0;
					q_q <= '0;
				end
			end
			ST_DIV: begin
				if (w_q.op != OP_CLIP) begin
				end else if (den_q == 0) begin
					if (dist_q < 0) fail_q <= 1'b1;
					div_q <= 5'd17;
				end else if (div_q == 5'd0) begin
					if (an < 0) begin
						// t below 0: a far bound below zero always misses
						if (den_q > 0) fail_q <= 1'b1;
						div_q <= 5'd17;
					end else if (an > ad) begin
						if (den_q < 0) fail_q <= 1'b1;
						div_q <= 5'd17;
					end else if (an == ad) begin
						if (den_q < 0) begin tn_q <= 17'(T_ONE); if (tf_q != 17'(T_ONE)) fail_q <= 1'b1; end
						div_q <= 5'd17;
					end else begin
						div_q <= 5'd1;
						r_q <= an;
					end
				end else if (div_q < 5'd17) begin
					div_q <= div_q + 5'd1;
					if (r2 >= ad) begin r_q <= r2 - ad; q_q <= {q_q[15:0], 1'b1}; end
					else begin r_q <= r2; q_q <= {q_q[15:0], 1'b0}; end
					if (div_q == 5'd16) begin
						if (den_q < 0) begin
							if ({q_q[15:0], r2 >= ad} > tn_q) begin
								tn_q <= {q_q[15:0], r2 >= ad};
								if (tf_q < {q_q[15:0], r2 >= ad}) fail_q <= 1'b1;
							end
						end else if ({q_q[15:0], r2 >= ad} < tf_q) begin
							tf_q <= {q_q[15:0], r2 >= ad};
							if ({q_q[15:0], r2 >= ad} < tn_q) fail_q <= 1'b1;
						end
					end
				end
			end
			ST_NEXT: begin
				pl_q <= pl_q + PW'(1);
				step_q <= '0;
				if (w_q.op == OP_INSIDE) res_q.inside_res <= inside_q;
			end
			ST_LERP: step_q <= step_q + 3'd1;
			default: ;
		endcase
		if (state_q == ST_LERP && step_q == 3'd7) begin
			res_q.hit <= 1'b1;
			res_q.t_near <= tn_q;
			res_q.hit_x <= hp_q[0];
			res_q.hit_y <= hp_q[1];
			res_q.hit_z <= hp_q[2];
		end
		if (out_load)
			out_q <= res_q;
	end

	// entry point: product for axis k lands at step k+2; round it, add start
	logic [1:0] lax;
	assign lax = step_q[1:0] - 2'd2;
	always_ff @(posedge clk) begin
		if (state_q != ST_LERP) begin
			lp_q <= '0;
		end else if (step_q >= 3'd2 && step_q <= 3'd4) begin
			lp_q <= acc;
			hp_q[lax] <= sel3(w_q, 1'b0, lax) + 32'(rnd);
		end
	end
endmodule
